// ===== rtl/core/spbps_pkg.sv =====
// spbps_pkg: shared widths and constants of the spi baud prescaler search unit
// no dependencies
`default_nettype none
package spbps_pkg;
  localparam int DATA_W     = 32;
  localparam int PRESC_N    = 4;
  localparam int PRESC_W    = 2;
  localparam int SCALER_W   = 9;
  localparam int CODE_W     = 8;
  localparam logic [SCALER_W-1:0] SCALER_MAX = 9'd256;
  localparam logic [SCALER_W-1:0] SCALER_ONE = 9'd1;
  localparam logic [DATA_W-1:0]   ERROR_INIT = 32'hFFFF_FFFF;
endpackage
`default_nettype wire

// ===== rtl/core/spbps_if.sv =====
// spbps_in_if / spbps_out_if: valid-ready channels of the search unit
// depends on spbps_pkg
`default_nettype none
interface spbps_in_if;
  logic                          valid;
  logic                          ready;
  logic [spbps_pkg::DATA_W-1:0]  clock_hz;
  logic [spbps_pkg::DATA_W-1:0]  target_baud;
  modport source (output valid, output clock_hz, output target_baud, input ready);
  modport sink   (input valid, input clock_hz, input target_baud, output ready);
endinterface

interface spbps_out_if;
  logic                          valid;
  logic                          ready;
  logic [spbps_pkg::PRESC_W-1:0] prescaler_code;
  logic [spbps_pkg::CODE_W-1:0]  scaler_code;
  logic [spbps_pkg::DATA_W-1:0]  actual_baud;
  modport source (output valid, output prescaler_code, output scaler_code,
                  output actual_baud, input ready);
  modport sink   (input valid, input prescaler_code, input scaler_code,
                  input actual_baud, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/spbps_div_pipe.sv =====
// spbps_div_pipe: restoring divider, one quotient bit per register stage
// standalone; carries a sideband word alongside each transaction
`default_nettype none
module spbps_div_pipe #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 32,
  parameter int SB_W  = 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             valid_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  input  wire logic [SB_W-1:0]  sb_i,
  output logic                  valid_o,
  output logic [NUM_W-1:0]      num_o,
  output logic [DEN_W-1:0]      den_o,
  output logic [NUM_W-1:0]      quo_o,
  output logic [SB_W-1:0]       sb_o
);
  logic             vld_s [NUM_W+1];
  logic [NUM_W-1:0] num_s [NUM_W+1];
  logic [DEN_W-1:0] den_s [NUM_W+1];
  logic [DEN_W-1:0] rem_s [NUM_W+1];
  logic [NUM_W-1:0] quo_s [NUM_W+1];
  logic [SB_W-1:0]  sb_s  [NUM_W+1];

  assign vld_s[0] = valid_i;
  assign num_s[0] = num_i;
  assign den_s[0] = den_i;
  assign rem_s[0] = '0;
  assign quo_s[0] = '0;
  assign sb_s[0]  = sb_i;

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W:0]   trial;
    logic             ge;
    logic             vld_r;
    logic [NUM_W-1:0] num_r;
    logic [DEN_W-1:0] den_r;
    logic [DEN_W-1:0] rem_r;
    logic [NUM_W-1:0] quo_r;
    logic [SB_W-1:0]  sb_r;

    assign trial = {rem_s[k], num_s[k][NUM_W-1-k]};
    assign ge    = trial >= {1'b0, den_s[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r <= num_s[k];
        den_r <= den_s[k];
        sb_r  <= sb_s[k];
        rem_r <= ge ? DEN_W'(trial - {1'b0, den_s[k]}) : trial[DEN_W-1:0];
        quo_r <= quo_s[k] | (NUM_W'(ge) << (NUM_W-1-k));
      end
    end

    assign vld_s[k+1] = vld_r;
    assign num_s[k+1] = num_r;
    assign den_s[k+1] = den_r;
    assign rem_s[k+1] = rem_r;
    assign quo_s[k+1] = quo_r;
    assign sb_s[k+1]  = sb_r;
  end

  assign valid_o = vld_s[NUM_W];
  assign num_o   = num_s[NUM_W];
  assign den_o   = den_s[NUM_W];
  assign quo_o   = quo_s[NUM_W];
  assign sb_o    = sb_s[NUM_W];
endmodule
`default_nettype wire

// ===== rtl/core/spi_baud_prescaler_search_unit.sv =====
// spi_baud_prescaler_search_unit: picks spi prescaler/scaler for a target baud
// depends on spbps_pkg, spbps_if and spbps_div_pipe
// stages from input to result: 32 divider stages for the ratio, one candidate
// stage, 32 divider stages for the four actual rates, one error stage and the
// output register; throughput one transaction per cycle unless the output stalls;
// a stalled output holds the whole pipeline; synchronous reset clears valid bits
`default_nettype none
module spi_baud_prescaler_search_unit (
  input  wire logic     clk,
  input  wire logic     rst_n,
  spbps_in_if.sink      in_if,
  spbps_out_if.source   out_if
);
  localparam int DW = spbps_pkg::DATA_W;
  localparam int PN = spbps_pkg::PRESC_N;
  localparam int SW = spbps_pkg::SCALER_W;
  localparam int LANE_SB_W = DW + 1 + PN;

  // pipeline advances whenever the output register is free or being drained
  logic en;
  logic out_vld_r;
  assign en          = !out_vld_r || out_if.ready;
  assign in_if.ready = en;

  // stage a: ratio = clock / baud, zero flag rides along
  logic          rat_vld;
  logic [DW-1:0] rat_clk, rat_baud, rat_quo;
  logic          rat_zero;

  spbps_div_pipe #(.NUM_W(DW), .DEN_W(DW), .SB_W(1)) u_ratio_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_if.valid && in_if.ready),
    .num_i   (in_if.clock_hz),
    .den_i   (in_if.target_baud),
    .sb_i    (in_if.clock_hz == '0 || in_if.target_baud == '0),
    .valid_o (rat_vld),
    .num_o   (rat_clk),
    .den_o   (rat_baud),
    .quo_o   (rat_quo),
    .sb_o    (rat_zero)
  );

  // stage b: candidate scalers, one per power-of-two prescaler
  logic          cb_vld_r;
  logic          cb_zero_r;
  logic [DW-1:0] cb_clk_r, cb_baud_r;
  logic [PN-1:0] cb_ok_r;
  logic [SW-1:0] cb_s_r [PN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cb_vld_r <= 1'b0;
    end else if (en) begin
      cb_vld_r <= rat_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cb_zero_r <= rat_zero;
      cb_clk_r  <= rat_clk;
      cb_baud_r <= rat_baud;
      for (int p = 0; p < PN; p++) begin
        // candidate counts only for a scaler in 1..256
        if ((rat_quo >> p) != '0 && (rat_quo >> p) <= DW'(spbps_pkg::SCALER_MAX)) begin
          cb_ok_r[p] <= 1'b1;
          cb_s_r[p]  <= SW'(rat_quo >> p);
        end else begin
          cb_ok_r[p] <= 1'b0;
          cb_s_r[p]  <= spbps_pkg::SCALER_ONE;
        end
      end
    end
  end

  // stage c: actual rate per lane, clock / (2^p * s) = (clock >> p) / s
  logic                 ln_vld;
  logic [LANE_SB_W-1:0] ln_sb;
  logic [DW-1:0]        ln_act [PN];
  logic [SW-1:0]        ln_s   [PN];
  logic [DW-1:0]        ln_clk;

  for (genvar p = 0; p < PN; p++) begin : g_lane
    if (p == 0) begin : g_main
      spbps_div_pipe #(.NUM_W(DW), .DEN_W(SW), .SB_W(LANE_SB_W)) u_act_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .valid_i (cb_vld_r),
        .num_i   (cb_clk_r),
        .den_i   (cb_s_r[p]),
        .sb_i    ({cb_baud_r, cb_zero_r, cb_ok_r}),
        .valid_o (ln_vld),
        .num_o   (ln_clk),
        .den_o   (ln_s[p]),
        .quo_o   (ln_act[p]),
        .sb_o    (ln_sb)
      );
    end else begin : g_side
      spbps_div_pipe #(.NUM_W(DW), .DEN_W(SW), .SB_W(1)) u_act_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .valid_i (cb_vld_r),
        .num_i   (cb_clk_r >> p),
        .den_i   (cb_s_r[p]),
        .sb_i    (1'b0),
        .valid_o (),
        .num_o   (),
        .den_o   (ln_s[p]),
        .quo_o   (ln_act[p]),
        .sb_o    ()
      );
    end
  end

  // stage d: absolute error of each candidate
  logic          er_vld_r;
  logic          er_zero_r;
  logic [DW-1:0] er_clk_r;
  logic [PN-1:0] er_ok_r;
  logic [DW-1:0] er_err_r [PN];
  logic [DW-1:0] er_act_r [PN];
  logic [SW-1:0] er_s_r   [PN];
  logic [DW-1:0] ln_baud;

  assign ln_baud = ln_sb[LANE_SB_W-1 -: DW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      er_vld_r <= 1'b0;
    end else if (en) begin
      er_vld_r <= ln_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      er_zero_r <= ln_sb[PN];
      er_ok_r   <= ln_sb[PN-1:0];
      er_clk_r  <= ln_clk;
      for (int p = 0; p < PN; p++) begin
        er_act_r[p] <= ln_act[p];
        er_s_r[p]   <= ln_s[p];
        er_err_r[p] <= (ln_act[p] > ln_baud) ? ln_act[p] - ln_baud : ln_baud - ln_act[p];
      end
    end
  end

  // stage e: strict minimum, earliest candidate wins a tie
  logic [DW-1:0]                 sel_err, sel_act;
  logic [spbps_pkg::PRESC_W-1:0] sel_p;
  logic [SW-1:0]                 sel_s;

  always_comb begin
    sel_err = spbps_pkg::ERROR_INIT;
    sel_act = er_clk_r;
    sel_p   = '0;
    sel_s   = spbps_pkg::SCALER_ONE;
    for (int p = 0; p < PN; p++) begin
      if (er_ok_r[p] && er_err_r[p] < sel_err) begin
        sel_err = er_err_r[p];
        sel_act = er_act_r[p];
        sel_p   = spbps_pkg::PRESC_W'(p);
        sel_s   = er_s_r[p];
      end
    end
  end

  logic [spbps_pkg::PRESC_W-1:0] out_p_r;
  logic [spbps_pkg::CODE_W-1:0]  out_s_r;
  logic [DW-1:0]                 out_act_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= er_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (er_zero_r) begin
        out_p_r   <= '0;
        out_s_r   <= '0;
        out_act_r <= '0;
      end else begin
        out_p_r   <= sel_p;
        out_s_r   <= spbps_pkg::CODE_W'(sel_s - spbps_pkg::SCALER_ONE);
        out_act_r <= sel_act;
      end
    end
  end

  assign out_if.valid          = out_vld_r;
  assign out_if.prescaler_code = out_p_r;
  assign out_if.scaler_code    = out_s_r;
  assign out_if.actual_baud    = out_act_r;
endmodule
`default_nettype wire
